/* design/moving_window_sum_product_top_macros.svh */
// assertion macros for the moving window sum and product block
`ifndef MOVING_WINDOW_SUM_PRODUCT_TOP_MACROS_SVH
`define MOVING_WINDOW_SUM_PRODUCT_TOP_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define MWSP_ASSERT_NOW(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("moving window check failed");

// condition must hold in the cycle after the trigger
`define MWSP_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("moving window check failed");

`endif

/* design/mwsp_pkg.sv */
// shared types and constants of the moving window sum and product block
package mwsp_pkg;

   localparam int VAL_W  = 48;
   localparam int HALF_W = 24;
   localparam int PROD_W = 96;

   localparam logic signed [VAL_W-1:0] VAL_MAXP = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [VAL_W-1:0] VAL_MINN = 48'sh8000_0000_0000;
   localparam logic [VAL_W-1:0]        MAG_MAXP = 48'h7FFF_FFFF_FFFF;

   // one stored history sample
   typedef struct packed {
      logic                    finite;
      logic signed [VAL_W-1:0] value;
   } hist_entry_type;

   // status and result of the fixed-point multiplier
   typedef struct packed {
      logic                    done;
      logic                    sat;
      logic signed [VAL_W-1:0] value;
   } mul_result_type;

endpackage

/* design/mwsp_hist_mem.sv */
// history sample memory, one write port and one registered read port
module mwsp_hist_mem #(
   parameter int DEPTH = 63,
   parameter int PTR_W = 6
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [PTR_W-1:0]        wr_addr,
   input  mwsp_pkg::hist_entry_type wr_data,
   input  logic [PTR_W-1:0]        rd_addr,
   output mwsp_pkg::hist_entry_type rd_data
);

   mwsp_pkg::hist_entry_type mem_ff [DEPTH];
   mwsp_pkg::hist_entry_type rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/mwsp_mul.sv */
// signed q-format multiplier from four 24x24 partial products, round and saturate
module mwsp_mul #(
   parameter int FRAC_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [mwsp_pkg::VAL_W-1:0]    op_a,
   input  logic signed [mwsp_pkg::VAL_W-1:0]    op_b,
   output mwsp_pkg::mul_result_type             res
);

   localparam int VW = mwsp_pkg::VAL_W;
   localparam int HW = mwsp_pkg::HALF_W;
   localparam int PW = mwsp_pkg::PROD_W;

   logic          busy_ff, busy_in;
   logic          fin_ff, fin_in;
   logic [1:0]    step_ff, step_in;
   logic          neg_ff, neg_in;
   logic [VW-1:0] ma_ff, ma_in;
   logic [VW-1:0] mb_ff, mb_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic          done_ff, done_in;
   logic          sat_ff, sat_in;
   logic signed [VW-1:0] val_ff, val_in;

   logic [HW-1:0] a_half;
   logic [HW-1:0] b_half;
   logic [2*HW-1:0] pp;
   logic [PW-1:0] pp_sh;
   logic [PW-1:0] q;
   logic [VW-1:0] lim;
   logic          ovf;

   // partial product of the halves chosen by the step
   always_comb begin
      a_half = step_ff[0] ? ma_ff[VW-1:HW] : ma_ff[HW-1:0];
      b_half = step_ff[1] ? mb_ff[VW-1:HW] : mb_ff[HW-1:0];
      pp     = a_half * b_half;
      case (step_ff)
         2'd0:    pp_sh = PW'(pp);
         2'd1:    pp_sh = PW'(pp) << HW;
         2'd2:    pp_sh = PW'(pp) << HW;
         2'd3:    pp_sh = PW'(pp) << (2 * HW);
         default: pp_sh = PW'(pp);
      endcase
   end

   // rounded magnitude, limit and overflow
   always_comb begin
      q   = acc_ff >> FRAC_BITS;
      lim = mwsp_pkg::MAG_MAXP + VW'(neg_ff);
      ovf = q > PW'(lim);
   end

   // sequencing of the four steps and the finish cycle
   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      step_in = step_ff;
      neg_in  = neg_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      sat_in  = sat_ff;
      val_in  = val_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 2'd0;
         neg_in  = op_a[VW-1] ^ op_b[VW-1];
         ma_in   = op_a[VW-1] ? VW'(-op_a) : VW'(op_a);
         mb_in   = op_b[VW-1] ? VW'(-op_b) : VW'(op_b);
         acc_in  = PW'(1) << (FRAC_BITS - 1);
      end else if (busy_ff) begin
         acc_in  = acc_ff + pp_sh;
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
         sat_in  = ovf;
         if (ovf) begin
            val_in = neg_ff ? mwsp_pkg::VAL_MINN : mwsp_pkg::VAL_MAXP;
         end else begin
            val_in = neg_ff ? -$signed(q[VW-1:0]) : $signed(q[VW-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      neg_ff <= neg_in;
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      acc_ff <= acc_in;
      sat_ff <= sat_in;
      val_ff <= val_in;
   end

   assign res.done  = done_ff;
   assign res.sat   = sat_ff;
   assign res.value = val_ff;

endmodule

/* design/moving_window_sum_product_top.sv */
// Moving window sum or product over a series of signed Q24.24 samples. Each
// accepted transaction yields one result transaction combining the current sample with
// up to window_length-1 earlier finite samples of the same series, newest first;
// tlast on the input ends the series and clears the history after its result.
// Each earlier sample in the window (at most WINDOW_MAX-1) is read in turn and, if
// finite, added in sum mode; in product mode only finite earlier samples go through the
// multiplier before the next one is read. An item that reads no earlier sample, because
// the history is empty, the window is one or the current sample is not finite, goes
// straight to the output state. The pace is set by the single read port of the history
// memory, one entry per cycle, and by the multiplier, which builds each product from
// four 24x24 partial products followed by a round and saturate step. A new transaction
// is taken while the previous result still waits in the output register, but not while
// an item is still being worked on.
`include "moving_window_sum_product_top_macros.svh"

module moving_window_sum_product_top #(
   parameter int WINDOW_MAX = 64,
   parameter int FRAC_BITS  = 24
) (
   input  logic                clock,
   input  logic                reset,
   // input channel
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic signed [47:0]  req_tdata,   // [47:0] sample_value
   input  logic [0:0]          req_tuser,   // [0] sample_finite
   input  logic                req_tlast,   // end_of_series
   // result channel
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic signed [47:0]  rsp_tdata,   // [47:0] window_result
   output logic [1:0]          rsp_tuser,   // [0] result_finite, [1] saturated
   // configuration writes
   input  logic                csr_wr_en,
   input  logic [0:0]          csr_index,
   input  logic [6:0]          csr_wdata
);

   localparam int VW         = mwsp_pkg::VAL_W;
   localparam int HIST_DEPTH = WINDOW_MAX - 1;
   localparam int PTR_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int CNT_W      = $clog2(WINDOW_MAX);
   localparam int LW         = ($clog2(WINDOW_MAX + 1) > 7) ? $clog2(WINDOW_MAX + 1) : 7;

   localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;
   localparam logic [0:0] REG_COMBINE_MODE  = 1'b1;

   localparam int         STATE_W = 3;
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_COMB  = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [STATE_W-1:0]   state_ff, state_in;
   logic [6:0]           win_len_ff, win_len_in;
   logic                 mode_ff, mode_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [PTR_W-1:0]     wp_ff, wp_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     remain_ff, remain_in;
   logic signed [VW-1:0] cur_ff, cur_in;
   logic                 fin_ff, fin_in;
   logic                 eos_ff, eos_in;
   logic signed [VW-1:0] acc_ff, acc_in;
   logic                 sat_ff, sat_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [VW-1:0] rsp_data_ff, rsp_data_in;
   logic                 rsp_fin_ff, rsp_fin_in;
   logic                 rsp_sat_ff, rsp_sat_in;

   logic [LW-1:0]        wl_ext;
   logic [LW-1:0]        eff;
   logic [LW-1:0]        eff_m1;
   logic [CNT_W-1:0]     earlier;
   logic [VW:0]          sum;
   logic                 add_ovf;
   logic signed [VW-1:0] add_val;
   logic                 out_load;
   logic                 mul_start;
   logic                 mem_wr;

   mwsp_pkg::hist_entry_type wr_entry;
   mwsp_pkg::hist_entry_type rd_entry;
   mwsp_pkg::mul_result_type mul_res;

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(HIST_DEPTH - 1) : p - PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(HIST_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   // history memory
   mwsp_hist_mem #(
      .DEPTH (HIST_DEPTH),
      .PTR_W (PTR_W)
   ) u_hist_mem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (wp_ff),
      .wr_data (wr_entry),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_entry)
   );

   // shared multiplier
   mwsp_mul #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (acc_ff),
      .op_b  (rd_entry.value),
      .res   (mul_res)
   );

   assign wr_entry.finite = fin_ff;
   assign wr_entry.value  = cur_ff;

   // number of earlier samples in the window
   always_comb begin
      wl_ext = LW'(win_len_ff);
      eff    = (wl_ext == '0) ? LW'(1) : wl_ext;
      if (eff > LW'(WINDOW_MAX)) begin
         eff = LW'(WINDOW_MAX);
      end
      eff_m1  = eff - LW'(1);
      earlier = (eff_m1 > LW'(count_ff)) ? count_ff : CNT_W'(eff_m1);
   end

   // saturating add of the stored sample
   always_comb begin
      sum     = {acc_ff[VW-1], acc_ff} + {rd_entry.value[VW-1], rd_entry.value};
      add_ovf = sum[VW] ^ sum[VW-1];
      if (add_ovf) begin
         add_val = sum[VW] ? mwsp_pkg::VAL_MINN : mwsp_pkg::VAL_MAXP;
      end else begin
         add_val = $signed(sum[VW-1:0]);
      end
   end

   assign out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == S_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      win_len_in   = win_len_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      wp_in        = wp_ff;
      rd_ptr_in    = rd_ptr_ff;
      remain_in    = remain_ff;
      cur_in       = cur_ff;
      fin_in       = fin_ff;
      eos_in       = eos_ff;
      acc_in       = acc_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_fin_in   = rsp_fin_ff;
      rsp_sat_in   = rsp_sat_ff;
      mul_start    = 1'b0;
      mem_wr       = 1'b0;

      // configuration writes
      if (csr_wr_en) begin
         case (csr_index)
            REG_WINDOW_LENGTH: win_len_in = csr_wdata;
            REG_COMBINE_MODE:  mode_in    = csr_wdata[0];
            default:           win_len_in = win_len_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cur_in    = req_tdata;
               fin_in    = req_tuser[0];
               eos_in    = req_tlast;
               acc_in    = req_tdata;
               sat_in    = 1'b0;
               remain_in = earlier;
               rd_ptr_in = ptr_dec(wp_ff);
               state_in  = (!req_tuser[0] || earlier == '0) ? S_OUT : S_READ;
            end
         end
         S_READ: begin
            rd_ptr_in = ptr_dec(rd_ptr_ff);
            state_in  = S_COMB;
         end
         S_COMB: begin
            if (!rd_entry.finite || !mode_ff) begin
               if (rd_entry.finite) begin
                  acc_in = add_val;
                  sat_in = sat_ff | add_ovf;
               end
               rd_ptr_in = ptr_dec(rd_ptr_ff);
               if (remain_ff == CNT_W'(1)) begin
                  state_in = S_OUT;
               end else begin
                  remain_in = remain_ff - CNT_W'(1);
               end
            end else begin
               mul_start = 1'b1;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_res.done) begin
               acc_in    = mul_res.value;
               sat_in    = sat_ff | mul_res.sat;
               rd_ptr_in = ptr_dec(rd_ptr_ff);
               if (remain_ff == CNT_W'(1)) begin
                  state_in = S_OUT;
               end else begin
                  remain_in = remain_ff - CNT_W'(1);
                  state_in  = S_COMB;
               end
            end
         end
         S_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = fin_ff ? acc_ff : '0;
               rsp_fin_in   = fin_ff;
               rsp_sat_in   = fin_ff & sat_ff;
               mem_wr       = 1'b1;
               if (eos_ff) begin
                  wp_in    = '0;
                  count_in = '0;
               end else begin
                  wp_in    = ptr_inc(wp_ff);
                  count_in = (count_ff == CNT_W'(HIST_DEPTH)) ? count_ff
                                                              : count_ff + CNT_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         win_len_ff   <= 7'd1;
         mode_ff      <= 1'b0;
         count_ff     <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_len_ff   <= win_len_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_ptr_ff   <= rd_ptr_in;
      remain_ff   <= remain_in;
      cur_ff      <= cur_in;
      fin_ff      <= fin_in;
      eos_ff      <= eos_in;
      acc_ff      <= acc_in;
      sat_ff      <= sat_in;
      rsp_data_ff <= rsp_data_in;
      rsp_fin_ff  <= rsp_fin_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_sat_ff, rsp_fin_ff};

   // checks on the sequencer, multiplier handoff and history clearing
   `MWSP_ASSERT_NEXT(a_result_shown, out_load, rsp_valid_ff)
   `MWSP_ASSERT_NOW(a_mul_done_in_mul, mul_res.done, state_ff == S_MUL)
   `MWSP_ASSERT_NEXT(a_series_end_clears, out_load && eos_ff, (count_ff == '0) && (wp_ff == '0))

endmodule
